// File: src/uvsph_pkg.sv
// Package for the UV-sphere mesh generator: constants, types and sine polynomial.
`default_nettype none
package uvsph_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 8;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    localparam logic [2:0] REG_SLICE_COUNT = 3'd0;
    localparam logic [2:0] REG_STACK_COUNT = 3'd1;
    localparam logic [2:0] REG_RADIUS      = 3'd2;
    localparam logic [2:0] REG_RING_STEP   = 3'd3;
    localparam logic [2:0] REG_SLICE_STEP  = 3'd4;

    localparam logic [15:0] POLY_C0 = 16'd51472;
    localparam logic [14:0] POLY_C1 = 15'd21024;
    localparam logic [11:0] POLY_C2 = 12'd2320;

    // Result item.
    typedef struct packed {
        logic               status;
        logic [15:0]        index_value;
        logic signed [15:0] pos_z;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
        logic [15:0]        vertex_number;
    } result_t;

endpackage
`default_nettype wire

// File: src/uvsph_sin.sv
// Pipelined fixed-point sine: quadrant fold plus three-term polynomial, five stages.
`default_nettype none
module uvsph_sin #(
    parameter int ANGLE_BITS = uvsph_pkg::ANGLE_BITS_DEF
) (
    input  wire                    clk,
    input  wire                    en,
    input  wire [ANGLE_BITS-1:0]   angle,
    output logic signed [16:0]     sin_q15
);
    localparam int QB = ANGLE_BITS - 2;

    logic [1:0]  quad;
    logic [15:0] frac;
    logic [15:0] u;

    logic [15:0] u1_reg;
    logic        neg1_reg;
    logic [15:0] u2_reg;
    logic [15:0] u_2_reg;
    logic        neg2_reg;
    logic [15:0] t1_reg;
    logic [15:0] u2_3_reg;
    logic [15:0] u_3_reg;
    logic        neg3_reg;
    logic [15:0] t2_reg;
    logic [15:0] u_4_reg;
    logic        neg4_reg;

    logic [31:0] p_u2;
    logic [27:0] p_t1;
    logic [31:0] p_t2;
    logic [31:0] p_s;

    assign quad = angle[ANGLE_BITS-1 -: 2];
    // quadrant fraction scaled to Q15
    assign frac = 16'((40'(angle[QB-1:0]) << 15) >> QB);
    assign u    = quad[0] ? 16'(17'd32768 - {1'b0, frac}) : frac;

    assign p_u2 = u1_reg * u1_reg;
    assign p_t1 = 28'(uvsph_pkg::POLY_C2) * 28'(u2_reg);
    assign p_t2 = 32'(16'(16'(uvsph_pkg::POLY_C1) - t1_reg)) * 32'(u2_3_reg);
    assign p_s  = 32'(16'(uvsph_pkg::POLY_C0 - t2_reg)) * 32'(u_4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg   <= u;
            neg1_reg <= quad[1];
            u2_reg   <= 16'(p_u2 >> 15);
            u_2_reg  <= u1_reg;
            neg2_reg <= neg1_reg;
            t1_reg   <= 16'(p_t1 >> 15);
            u2_3_reg <= u2_reg;
            u_3_reg  <= u_2_reg;
            neg3_reg <= neg2_reg;
            t2_reg   <= 16'(p_t2 >> 15);
            u_4_reg  <= u_3_reg;
            neg4_reg <= neg3_reg;
            sin_q15  <= neg4_reg ? -$signed({1'b0, 16'(p_s >> 15)})
                                 : $signed({1'b0, 16'(p_s >> 15)});
        end
    end
endmodule
`default_nettype wire

// File: src/uv_sphere_mesh_generator.sv
// Top level of the UV-sphere mesh generator: request decode, trig and scaling pipeline.
//
// channel  direction  handshake              payload
// s_axis   in         s_axis_tvalid/tready   tdata {corner,slice,ring}, tuser kind
// m_axis   out        m_axis_tvalid/tready   tdata result fields, tuser status
// cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Nine register stages from request to result; one item per cycle sustained.
// Latency is set by the angle multiply, the sine polynomial (five stages) and
// the radius scaling multiplies. The whole pipe advances together; when the
// output stage holds an unaccepted result, every stage holds. Reset clears
// valid bits and restores register defaults.
`default_nettype none
module uv_sphere_mesh_generator #(
    parameter int ANGLE_BITS = uvsph_pkg::ANGLE_BITS_DEF,
    parameter int COUNT_BITS = uvsph_pkg::COUNT_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // ring[7:0], slice[15:8], corner[18:16], zero
    input  wire         s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [79:0] m_axis_tdata,   // vertex_number, pos_x, pos_y, pos_z, index_value
    output logic        m_axis_tuser,   // status
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    localparam int DEPTH = 9;
    localparam logic [COUNT_BITS-1:0] CMASK = '1;

    logic [7:0]  slice_count_reg, stack_count_reg;
    logic [14:0] radius_reg;
    logic [15:0] ring_step_reg, slice_step_reg;

    logic adv;
    logic [DEPTH-1:0] vld_reg;

    logic kind;
    logic [7:0] ring, slice, S, T;
    logic [2:0] corner;
    logic [8:0] V;

    assign kind   = s_axis_tuser;
    assign ring   = s_axis_tdata[7:0];
    assign slice  = s_axis_tdata[15:8];
    assign corner = s_axis_tdata[18:16];
    assign S = slice_count_reg & 8'(CMASK);
    assign T = stack_count_reg & 8'(CMASK);
    assign V = {1'b0, S} + 9'd1;

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_count_reg <= 8'd20;
            stack_count_reg <= 8'd20;
            radius_reg      <= 15'd256;
            ring_step_reg   <= 16'd1638;
            slice_step_reg  <= 16'd3277;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                uvsph_pkg::REG_SLICE_COUNT: slice_count_reg <= cfg_data[7:0];
                uvsph_pkg::REG_STACK_COUNT: stack_count_reg <= cfg_data[7:0];
                uvsph_pkg::REG_RADIUS:      radius_reg      <= cfg_data[14:0];
                uvsph_pkg::REG_RING_STEP:   ring_step_reg   <= cfg_data;
                uvsph_pkg::REG_SLICE_STEP:  slice_step_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- stage 1: decode, vertex number, index, angle products ----
    logic [15:0] base_next;   // 1+(ring-1)*V
    logic [15:0] pole_next;   // 1+(T-1)*V
    logic        err_next;
    logic [1:0]  vmode_next;  // 0 body, 1 top pole, 2 bottom pole
    logic [15:0] idx_next;
    logic [15:0] a_idx, b_idx, c_idx;

    assign base_next = 16'(17'd1 + 17'(ring - 8'd1) * 17'(V));
    assign pole_next = 16'(17'd1 + 17'(T - 8'd1) * 17'(V));
    assign a_idx = base_next + 16'(slice);
    assign b_idx = a_idx + 16'(V);
    assign c_idx = pole_next - 16'(V) + 16'(slice);

    always_comb
    begin
        err_next   = 1'b0;
        vmode_next = 2'd0;
        idx_next   = '0;
        if (S < 8'd3 || T < 8'd3)
            err_next = 1'b1;
        else if (kind == uvsph_pkg::KIND_VERTEX)
        begin
            if (ring > T || slice > S)
                err_next = 1'b1;
            else if (ring == 8'd0)
                vmode_next = 2'd1;
            else if (ring == T)
                vmode_next = 2'd2;
        end
        else
        begin
            if (ring >= T || slice >= S)
                err_next = 1'b1;
            else if (ring == 8'd0 || ring == T - 8'd1)
            begin
                if (corner > 3'd2)
                    err_next = 1'b1;
                else if (ring == 8'd0)
                    idx_next = (corner == 3'd0) ? 16'd0 :
                               (corner == 3'd1) ? 16'(slice) + 16'd2 : 16'(slice) + 16'd1;
                else
                    idx_next = (corner == 3'd0) ? pole_next :
                               (corner == 3'd1) ? c_idx : c_idx + 16'd1;
            end
            else
            begin
                case (corner)
                    3'd0:       idx_next = a_idx;
                    3'd1, 3'd4: idx_next = a_idx + 16'd1;
                    3'd2, 3'd3: idx_next = b_idx;
                    3'd5:       idx_next = b_idx + 16'd1;
                    default:    err_next = 1'b1;
                endcase
            end
        end
    end

    logic [ANGLE_BITS-1:0] phi_reg, th_reg, phic_reg, thc_reg;
    logic [ANGLE_BITS-1:0] phi_a, th_a;
    localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    assign phi_a = ANGLE_BITS'(24'(ring) * 24'(ring_step_reg));
    assign th_a  = ANGLE_BITS'(24'(slice) * 24'(slice_step_reg));

    // sideband carried alongside the trig pipe
    typedef struct packed {
        logic        kind;
        logic        err;
        logic [1:0]  vmode;
        logic [15:0] vnum;
        logic [15:0] idx;
    } side_t;

    side_t side_reg [DEPTH-1];
    side_t side_in;

    always_comb
    begin
        side_in.kind  = kind;
        side_in.err   = err_next;
        side_in.vmode = vmode_next;
        side_in.vnum  = (ring == 8'd0) ? 16'd0 : (ring == T) ? pole_next : a_idx;
        side_in.idx   = idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            phi_reg  <= phi_a;
            th_reg   <= th_a;
            phic_reg <= phi_a + QTR;
            thc_reg  <= th_a + QTR;
            side_reg[0] <= side_in;
            for (int i = 1; i < DEPTH - 1; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
    end

    // ---- stages 2-6: four sines ----
    logic signed [16:0] sphi, cphi, sth, cth;
    uvsph_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sphi (.clk, .en(adv), .angle(phi_reg),  .sin_q15(sphi));
    uvsph_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cphi (.clk, .en(adv), .angle(phic_reg), .sin_q15(cphi));
    uvsph_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sth  (.clk, .en(adv), .angle(th_reg),   .sin_q15(sth));
    uvsph_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cth  (.clk, .en(adv), .angle(thc_reg),  .sin_q15(cth));

    // ---- stage 7: R*sin(phi), R*cos(phi); stage 8: products; stage 9: round ----
    logic signed [32:0] rs_reg, rc_reg;
    logic signed [16:0] sth7_reg, cth7_reg;
    logic signed [49:0] px_reg, pz_reg;
    logic signed [32:0] py_reg;
    logic signed [15:0] x_fin, y_fin, z_fin;
    side_t sd;

    function automatic logic signed [15:0] sat_round(input logic signed [49:0] p,
                                                     input int sh);
        logic signed [49:0] r;
        begin
            r = (p + (50'sd1 <<< (sh - 1))) >>> sh;
            if (r > 50'sd32767) sat_round = 16'sh7fff;
            else if (r < -50'sd32768) sat_round = 16'sh8000;
            else sat_round = 16'(r);
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs_reg   <= $signed({1'b0, radius_reg}) * sphi;
            rc_reg   <= $signed({1'b0, radius_reg}) * cphi;
            sth7_reg <= sth;
            cth7_reg <= cth;
            px_reg   <= rs_reg * cth7_reg;
            pz_reg   <= rs_reg * sth7_reg;
            py_reg   <= rc_reg;
        end
    end

    assign sd = side_reg[DEPTH-2];

    always_comb
    begin
        x_fin = sat_round(px_reg, 30);
        y_fin = sat_round(50'(py_reg), 15);
        z_fin = sat_round(pz_reg, 30);
        if (sd.vmode != 2'd0)
        begin
            x_fin = '0;
            z_fin = '0;
            y_fin = (sd.vmode == 2'd1) ? $signed({1'b0, radius_reg})
                                       : -$signed({1'b0, radius_reg});
        end
    end

    uvsph_pkg::result_t res_next, res_reg;

    always_comb
    begin
        res_next = '0;
        if (sd.err)
            res_next.status = 1'b1;
        else if (sd.kind == uvsph_pkg::KIND_INDEX)
            res_next.index_value = sd.idx;
        else
        begin
            res_next.vertex_number = sd.vnum;
            res_next.pos_x = x_fin;
            res_next.pos_y = y_fin;
            res_next.pos_z = z_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tdata  = {res_reg.index_value, res_reg.pos_z, res_reg.pos_y,
                            res_reg.pos_x, res_reg.vertex_number};
    assign m_axis_tuser  = res_reg.status;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 80'd0)
        else $error("error result carries data");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(vld_reg))
        else $error("pipe moved during stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
endmodule
`default_nettype wire
